// File: design/nearest_palette_color_defines.svh
// Assertion macros for the nearest palette colour block.
`ifndef NEAREST_PALETTE_COLOR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_DEFINES_SVH

`ifndef SYNTHESIS

`define NPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npc assertion failed");

`define NPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npc assertion failed");

`else

`define NPC_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define NPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/npc_pkg.sv
// Shared types, palette table and distance function for the palette quantiser.
package npc_pkg;

  localparam int PAL_SIZE = 16;
  localparam int IDX_W    = 4;
  localparam int COL_W    = 8;
  localparam int DIST_W   = 18;
  localparam int LATENCY  = PAL_SIZE + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [COL_W-1:0] PAL_R [PAL_SIZE] = '{
    8'h00, 8'h44, 8'h88, 8'hbb, 8'h99, 8'h66, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h33, 8'hff, 8'hdd, 8'hff, 8'hff, 8'hff};
  localparam logic [COL_W-1:0] PAL_G [PAL_SIZE] = '{
    8'h00, 8'h44, 8'h88, 8'hbb, 8'h66, 8'h33, 8'h66, 8'haa,
    8'h99, 8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'hff, 8'hff};
  localparam logic [COL_W-1:0] PAL_B [PAL_SIZE] = '{
    8'h00, 8'h44, 8'h88, 8'hbb, 8'h33, 8'h00, 8'h00, 8'h00,
    8'hff, 8'hcc, 8'h99, 8'h99, 8'h00, 8'h00, 8'h00, 8'hff};

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [DIST_W-1:0] cur_d;
    logic [DIST_W-1:0] best_d;
    logic [IDX_W-1:0]  best_idx;
  } stage_t;

  function automatic logic [2*COL_W-1:0] sq_diff(input logic [COL_W-1:0] a,
                                                  input logic [COL_W-1:0] b);
    logic [COL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  function automatic logic [DIST_W-1:0] pal_dist(input logic [COL_W-1:0] r,
                                                 input logic [COL_W-1:0] g,
                                                 input logic [COL_W-1:0] b,
                                                 input logic [IDX_W-1:0] k);
    logic [DIST_W-1:0] sr, sg, sb;
    sr = DIST_W'(sq_diff(r, PAL_R[k]));
    sg = DIST_W'(sq_diff(g, PAL_G[k]));
    sb = DIST_W'(sq_diff(b, PAL_B[k]));
    return sr + sg + sb;
  endfunction

endpackage

// File: design/npc_cell.sv
// One cell of the search chain: distance to its own entry, compare for the previous one.
module npc_cell import npc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  stage_t           prev,
  output stage_t           next
);

  logic              valid;
  logic              valid_next;
  logic [COL_W-1:0]  red, green, blue;
  logic [DIST_W-1:0] cur_d;
  logic [DIST_W-1:0] best_d, best_d_next;
  logic [IDX_W-1:0]  best_idx, best_idx_next;

  assign valid_next = prev.valid;

  // previous cell's distance belongs to entry cell_idx - 1
  always_comb begin
    if (prev.cur_d < prev.best_d) begin
      best_d_next   = prev.cur_d;
      best_idx_next = cell_idx - IDX_W'(1);
    end else begin
      best_d_next   = prev.best_d;
      best_idx_next = prev.best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    red      <= prev.red;
    green    <= prev.green;
    blue     <= prev.blue;
    cur_d    <= pal_dist(prev.red, prev.green, prev.blue, cell_idx);
    best_d   <= best_d_next;
    best_idx <= best_idx_next;
  end

  assign next = '{valid: valid, red: red, green: green, blue: blue, cur_d: cur_d,
                  best_d: best_d, best_idx: best_idx};

endmodule

// File: design/npc_out.sv
// Final compare for the last entry and the registered result.
module npc_out import npc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  stage_t           last,
  output logic             done,
  output logic [IDX_W-1:0] pal_index,
  output logic [COL_W-1:0] out_red,
  output logic [COL_W-1:0] out_green,
  output logic [COL_W-1:0] out_blue
);

  logic [IDX_W-1:0] pick;

  assign pick = (last.cur_d < last.best_d) ? IDX_W'(PAL_SIZE - 1) : last.best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    pal_index <= pick;
    out_red   <= PAL_R[pick];
    out_green <= PAL_G[pick];
    out_blue  <= PAL_B[pick];
  end

endmodule

// File: design/nearest_palette_color.sv
// Top level of the nearest palette colour quantiser.
//
// channel   direction  transaction                       fields
// pixel     in         start && !busy at a clock edge    in_red, in_green, in_blue
// result    out        done for one cycle                pal_index, out_red, out_green, out_blue
//
// One pixel accepted every cycle while busy is low; each result passes through
// the chain of 16 cells, one per palette entry, and then the result register.
// busy is high only during reset; pixels offered then are dropped.
// Results cannot be held off; done and the result ports are valid for exactly one cycle.
`include "nearest_palette_color_defines.svh"

module nearest_palette_color import npc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [COL_W-1:0] in_red,
  input  logic [COL_W-1:0] in_green,
  input  logic [COL_W-1:0] in_blue,
  output logic             done,
  output logic [IDX_W-1:0] pal_index,
  output logic [COL_W-1:0] out_red,
  output logic [COL_W-1:0] out_green,
  output logic [COL_W-1:0] out_blue
);

  stage_t chain [PAL_SIZE+1];

  assign busy = rst;

  assign chain[0] = '{valid: start && !busy, red: in_red, green: in_green, blue: in_blue,
                      cur_d: DIST_MAX, best_d: DIST_MAX, best_idx: '0};

  for (genvar i = 0; i < PAL_SIZE; i++) begin : g_cell
    npc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(i)),
      .prev     (chain[i]),
      .next     (chain[i+1])
    );
  end

  npc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .last      (chain[PAL_SIZE]),
    .done      (done),
    .pal_index (pal_index),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  `NPC_ASSERT_IMPLY(a_done_follows_accept, clk, rst, done, $past(start && !rst, LATENCY))
  `NPC_ASSERT_IMPLY(a_colour_matches_index, clk, rst, done, out_red == PAL_R[pal_index] && out_green == PAL_G[pal_index] && out_blue == PAL_B[pal_index])
  `NPC_ASSERT_NEXT(a_last_stage_to_done, clk, rst, chain[PAL_SIZE].valid, done)

endmodule
